[hw/rtl/xdh_pkg.sv]
package xdh_pkg;

	// drive slots are always two; drives at or above NUM_DRIVES never report ready
	localparam int DRIVE_SLOTS     = 2;
	localparam int NUM_DRIVES      = 2;
	localparam int STORE_DEPTH_DEF = 16;
	localparam int BLOCK_BYTES     = 14;

	// bus access kind and port offsets
	localparam logic       BUS_RD      = 1'b0;
	localparam logic       BUS_WR      = 1'b1;
	localparam logic [1:0] OFS_DATA    = 2'd0;
	localparam logic [1:0] OFS_STATUS  = 2'd1;
	localparam logic [1:0] OFS_SELECT  = 2'd2;
	localparam logic [1:0] OFS_CONTROL = 2'd3;

	// configuration register indexes
	localparam logic REG_DRIVE_PRESENT = 1'b0;
	localparam logic REG_DIP_SWITCHES  = 1'b1;

	// status bits
	localparam logic [5:0] ST_READY     = 6'h01;
	localparam logic [5:0] ST_INPUT     = 6'h02;
	localparam logic [5:0] ST_COMMAND   = 6'h04;
	localparam logic [5:0] ST_SELECT    = 6'h08;
	localparam logic [5:0] ST_REQUEST   = 6'h10;
	localparam logic [5:0] ST_INTERRUPT = 6'h20;
	localparam logic [5:0] ST_FINISH    = ST_INTERRUPT | ST_INPUT | ST_REQUEST
		| ST_COMMAND | ST_READY;

	// command opcodes
	localparam logic [7:0] OP_TEST_READY = 8'h00;
	localparam logic [7:0] OP_RECAL      = 8'h01;
	localparam logic [7:0] OP_SENSE      = 8'h03;
	localparam logic [7:0] OP_FMT_DRIVE  = 8'h04;
	localparam logic [7:0] OP_VERIFY     = 8'h05;
	localparam logic [7:0] OP_FMT_TRACK  = 8'h06;
	localparam logic [7:0] OP_FMT_BAD    = 8'h07;
	localparam logic [7:0] OP_READ       = 8'h08;
	localparam logic [7:0] OP_WRITE      = 8'h0a;
	localparam logic [7:0] OP_SEEK       = 8'h0b;
	localparam logic [7:0] OP_INIT_DRIVE = 8'h0c;
	localparam logic [7:0] OP_ECC_LEN    = 8'h0d;
	localparam logic [7:0] OP_RD_BUF     = 8'h0e;
	localparam logic [7:0] OP_WR_BUF     = 8'h0f;
	localparam logic [7:0] OP_RAM_DIAG   = 8'he0;
	localparam logic [7:0] OP_DRV_DIAG   = 8'he3;
	localparam logic [7:0] OP_CTL_DIAG   = 8'he4;
	localparam logic [7:0] OP_RD_LONG    = 8'he5;
	localparam logic [7:0] OP_WR_LONG    = 8'he6;

	localparam logic [7:0] CC_BAD_CMD     = 8'h22;
	localparam logic [7:0] ERR_CHS_VALID  = 8'h80;
	localparam logic [7:0] ERR_NOT_READY  = 8'h04;
	localparam logic [7:0] ERR_SENSE_MASK = 8'hc4;

	localparam logic [9:0] CYL_LIMIT_RST  = 10'd612;
	localparam logic [4:0] HEAD_LIMIT_RST = 5'd4;
	localparam logic [9:0] RCS_RST        = 10'd613;
	localparam logic [9:0] PRECOMP_RST    = 10'd613;
	localparam logic [7:0] ECC_LEN_RST    = 8'd11;

	localparam logic [2:0] IRQ_PRIMARY   = 3'd2;
	localparam logic [2:0] IRQ_ALTERNATE = 3'd5;

	typedef struct packed {
		logic       cmd;
		logic [1:0] off;
		logic [7:0] wdata;
	} access_t;

	typedef struct packed {
		logic [7:0]      completion;
		logic [7:0]      error;
		logic            drive;
		logic            take_chs;
		logic            set_geom;
		logic [4:0]      head;
		logic [5:0]      sector;
		logic [9:0]      cylinder;
		logic [7:0]      count;
		logic [7:0]      step;
		logic [9:0]      cyl_limit;
		logic [4:0]      head_limit;
		logic [9:0]      rc_start;
		logic [9:0]      precomp;
		logic [7:0]      ecc_len;
		logic [2:0]      push_cnt;
		logic [4:0][7:0] push_data;
	} launch_t;

	function automatic logic is_known_op(input logic [7:0] op);
		case (op) inside
			OP_TEST_READY, OP_RECAL, OP_SENSE, OP_FMT_DRIVE, OP_VERIFY, OP_FMT_TRACK,
			OP_FMT_BAD, OP_READ, OP_WRITE, OP_SEEK, OP_INIT_DRIVE, OP_ECC_LEN,
			OP_RD_BUF, OP_WR_BUF, OP_RAM_DIAG, OP_DRV_DIAG, OP_CTL_DIAG, OP_RD_LONG,
			OP_WR_LONG: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// three detail bytes: drive/head, cylinder high/sector, cylinder low
	function automatic logic [2:0][7:0] chs_bytes(input logic d, input logic [4:0] head,
		input logic [5:0] sector, input logic [9:0] cyl);
		logic [2:0][7:0] b;
		b[0] = {2'b00, d, head};
		b[1] = {cyl[9:8], sector};
		b[2] = cyl[7:0];
		return b;
	endfunction

endpackage

[hw/rtl/xdh_launch.sv]
module xdh_launch
	import xdh_pkg::*;
(
	input  logic [BLOCK_BYTES-1:0][7:0] blk,
	input  logic [1:0]                  drive_present,
	input  logic [7:0]                  error_cur,
	input  logic [4:0]                  head_cur [DRIVE_SLOTS],
	input  logic [5:0]                  sector_cur [DRIVE_SLOTS],
	input  logic [9:0]                  cyl_cur [DRIVE_SLOTS],
	input  logic [7:0]                  ecc_cur [DRIVE_SLOTS],
	output launch_t                     res
);

	logic            d;
	logic [7:0]      op;
	logic            ready;
	logic            check;
	logic            with_err;
	logic            bad;
	logic [2:0][7:0] chs;

	always_comb begin
		op = blk[0];
		d  = blk[1][5];
		ready = drive_present[d] && (32'(d) < NUM_DRIVES);

		res.take_chs = 1'b0;
		check        = 1'b0;
		with_err     = 1'b1;
		case (op) inside
			OP_RECAL, OP_INIT_DRIVE: res.take_chs = 1'b1;
			OP_FMT_DRIVE, OP_VERIFY, OP_FMT_TRACK, OP_FMT_BAD, OP_SEEK, OP_DRV_DIAG,
			OP_WRITE, OP_WR_LONG: begin
				res.take_chs = 1'b1;
				check        = 1'b1;
			end
			OP_READ, OP_RD_LONG: begin
				res.take_chs = 1'b1;
				check        = 1'b1;
				with_err     = 1'b0;
			end
			OP_TEST_READY: begin
				check    = 1'b1;
				with_err = 1'b0;
			end
			OP_SENSE: with_err = 1'b0;
			default: ;
		endcase
		res.set_geom = (op == OP_INIT_DRIVE);

		bad            = check && !ready;
		res.drive      = d;
		res.completion = {2'b00, d, 3'b000, bad, 1'b0};
		res.error      = (res.take_chs ? ERR_CHS_VALID : 8'h00) | (bad ? ERR_NOT_READY : 8'h00);

		res.head     = res.take_chs ? blk[1][4:0] : head_cur[d];
		res.sector   = res.take_chs ? blk[2][5:0] : sector_cur[d];
		res.cylinder = res.take_chs ? {blk[2][7:6], blk[3]} : cyl_cur[d];
		res.count    = blk[4];
		res.step     = blk[5];

		res.cyl_limit  = {blk[6][1:0], blk[7]};
		res.head_limit = blk[8][4:0];
		res.rc_start   = {blk[9][1:0], blk[10]};
		res.precomp    = {blk[11][1:0], blk[12]};
		res.ecc_len    = blk[13];

		chs = chs_bytes(d, res.head, res.sector, res.cylinder);

		res.push_data = '0;
		case (op)
			OP_SENSE: begin
				res.push_data[0] = error_cur & ERR_SENSE_MASK;
				res.push_data[1] = chs[0];
				res.push_data[2] = chs[1];
				res.push_data[3] = chs[2];
				res.push_data[4] = res.completion;
				res.push_cnt     = 3'd5;
			end
			OP_ECC_LEN: begin
				res.push_data[0] = ecc_cur[d];
				res.push_data[1] = res.completion;
				res.push_cnt     = 3'd2;
			end
			default: begin
				res.push_data[0] = res.completion;
				res.push_data[1] = res.error;
				res.push_data[2] = chs[0];
				res.push_data[3] = chs[1];
				res.push_data[4] = chs[2];
				if (with_err && res.completion[1]) begin
					res.push_cnt = res.error[7] ? 3'd5 : 3'd2;
				end else begin
					res.push_cnt = 3'd1;
				end
			end
		endcase
	end

endmodule

[hw/rtl/xdh_regs.sv]
module xdh_regs
	import xdh_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  access_t    acc,
	input  logic       cfg_we,
	input  logic       cfg_addr,
	input  logic [7:0] cfg_wdata,
	output logic [7:0] rd_data,
	output logic       irq_next,
	output logic [2:0] irq_num
);

	localparam int PW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);

	logic [7:0]    store_q [STORE_DEPTH];
	logic [CW-1:0] pending_q;
	logic [PW-1:0] pos_q;
	logic [5:0]    status_q;
	logic [7:0]    compl_q;
	logic [7:0]    error_q;
	logic          drive_q;
	logic [7:0]    control_q;
	logic          irq_q;
	logic [1:0]    present_q;
	logic [7:0]    dip_q;
	logic [9:0]    cyl_q [DRIVE_SLOTS];
	logic [4:0]    head_q [DRIVE_SLOTS];
	logic [5:0]    sector_q [DRIVE_SLOTS];
	logic [7:0]    count_q [DRIVE_SLOTS];
	logic [7:0]    stepopt_q [DRIVE_SLOTS];
	logic [9:0]    cyl_lim_q [DRIVE_SLOTS];
	logic [4:0]    head_lim_q [DRIVE_SLOTS];
	logic [9:0]    rcs_q [DRIVE_SLOTS];
	logic [9:0]    precomp_q [DRIVE_SLOTS];
	logic [7:0]    ecc_q [DRIVE_SLOTS];

	logic [7:0]    store_d [STORE_DEPTH];
	logic [CW-1:0] pending_d;
	logic [PW-1:0] pos_d;
	logic [5:0]    status_d;
	logic [7:0]    compl_d;
	logic [7:0]    error_d;
	logic          drive_d;
	logic [7:0]    control_d;
	logic          irq_d;
	logic [9:0]    cyl_d [DRIVE_SLOTS];
	logic [4:0]    head_d [DRIVE_SLOTS];
	logic [5:0]    sector_d [DRIVE_SLOTS];
	logic [7:0]    count_d [DRIVE_SLOTS];
	logic [7:0]    stepopt_d [DRIVE_SLOTS];
	logic [9:0]    cyl_lim_d [DRIVE_SLOTS];
	logic [4:0]    head_lim_d [DRIVE_SLOTS];
	logic [9:0]    rcs_d [DRIVE_SLOTS];
	logic [9:0]    precomp_d [DRIVE_SLOTS];
	logic [7:0]    ecc_d [DRIVE_SLOTS];

	logic [BLOCK_BYTES-1:0][7:0] blk;
	launch_t                     lres;
	logic                        launch_go;

	function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
		return (p == PW'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// block as it stands once the byte of this access is in place
	always_comb begin
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			blk[i] = (PW'(i) == pos_q) ? acc.wdata : store_q[i];
		end
	end

	xdh_launch u_launch (
		.blk           (blk),
		.drive_present (present_q),
		.error_cur     (error_q),
		.head_cur      (head_q),
		.sector_cur    (sector_q),
		.cyl_cur       (cyl_q),
		.ecc_cur       (ecc_q),
		.res           (lres)
	);

	always_comb begin
		logic [CW-1:0]   need;
		logic [PW-1:0]   wpos;
		logic [PW-1:0]   push_base;
		logic [2:0]      push_cnt;
		logic [4:0][7:0] push_data;
		logic [PW:0]     idx;
		logic [2:0][7:0] chs;
		logic [5:0]      st;

		store_d    = store_q;
		pending_d  = pending_q;
		pos_d      = pos_q;
		status_d   = status_q;
		compl_d    = compl_q;
		error_d    = error_q;
		drive_d    = drive_q;
		control_d  = control_q;
		irq_d      = irq_q;
		cyl_d      = cyl_q;
		head_d     = head_q;
		sector_d   = sector_q;
		count_d    = count_q;
		stepopt_d  = stepopt_q;
		cyl_lim_d  = cyl_lim_q;
		head_lim_d = head_lim_q;
		rcs_d      = rcs_q;
		precomp_d  = precomp_q;
		ecc_d      = ecc_q;
		rd_data    = 8'hff;
		launch_go  = 1'b0;
		push_base  = '0;
		push_cnt   = '0;
		push_data  = '0;
		need       = '0;
		wpos       = '0;
		st         = '0;
		chs        = chs_bytes(drive_q, head_q[drive_q], sector_q[drive_q], cyl_q[drive_q]);

		if (step) begin
			if (acc.cmd == BUS_WR) begin
				case (acc.off)
					OFS_DATA: begin
						if (pending_q == '0 && !is_known_op(acc.wdata)) begin
							// unknown opcode: answered at once, result bytes from the store start
							compl_d   = CC_BAD_CMD;
							status_d  = status_q | ST_FINISH;
							pos_d     = '0;
							push_base = '0;
							push_data = {chs[2], chs[1], chs[0], error_q, CC_BAD_CMD};
							push_cnt  = error_q[7] ? 3'd5 : 3'd2;
							pending_d = CW'(push_cnt);
							if (control_q[1]) irq_d = 1'b1;
						end else begin
							if (pending_q == '0) begin
								need = (acc.wdata == OP_INIT_DRIVE) ? CW'(14) : CW'(6);
								wpos = '0;
								st   = (status_q & ~(ST_READY | ST_INPUT)) | ST_REQUEST;
							end else begin
								need = pending_q;
								wpos = pos_q;
								st   = status_q;
							end
							store_d[wpos] = acc.wdata;
							pos_d         = pos_inc(wpos);
							pending_d     = need - 1'b1;
							status_d      = st | ST_READY;
							if (need == CW'(1)) begin
								launch_go = 1'b1;
								status_d  = st | ST_FINISH;
								pos_d     = '0;
								compl_d   = lres.completion;
								error_d   = lres.error;
								drive_d   = lres.drive;
								push_base = '0;
								push_data = lres.push_data;
								push_cnt  = lres.push_cnt;
								pending_d = CW'(lres.push_cnt);
								if (control_q[1]) irq_d = 1'b1;
								if (lres.take_chs) begin
									head_d[lres.drive]    = lres.head;
									sector_d[lres.drive]  = lres.sector;
									cyl_d[lres.drive]     = lres.cylinder;
									count_d[lres.drive]   = lres.count;
									stepopt_d[lres.drive] = lres.step;
								end
								if (lres.set_geom) begin
									cyl_lim_d[lres.drive]  = lres.cyl_limit;
									head_lim_d[lres.drive] = lres.head_limit;
									rcs_d[lres.drive]      = lres.rc_start;
									precomp_d[lres.drive]  = lres.precomp;
									ecc_d[lres.drive]      = lres.ecc_len;
								end
							end
						end
					end
					OFS_STATUS: begin
						// controller reset: irq line and control byte are kept
						for (int i = 0; i < DRIVE_SLOTS; i++) begin
							cyl_d[i]    = '0;
							head_d[i]   = '0;
							sector_d[i] = '0;
						end
						for (int i = 0; i < STORE_DEPTH; i++) begin
							store_d[i] = '0;
						end
						compl_d   = '0;
						status_d  = ST_COMMAND | ST_READY;
						pos_d     = '0;
						pending_d = '0;
					end
					OFS_SELECT: begin
						status_d = (status_q & ~ST_INTERRUPT) | ST_SELECT;
					end
					default: begin
						control_d = acc.wdata;
						if (!acc.wdata[1]) irq_d = 1'b0;
					end
				endcase
			end else begin
				case (acc.off)
					OFS_DATA: begin
						if (pending_q != '0) begin
							rd_data   = store_q[pos_q];
							pos_d     = pos_inc(pos_q);
							pending_d = pending_q - 1'b1;
							status_d  = status_q & ~ST_INTERRUPT;
							if (pending_q == CW'(1)) begin
								status_d = (status_q & ~(ST_INTERRUPT | ST_INPUT | ST_REQUEST
									| ST_SELECT)) | ST_COMMAND;
							end
						end
					end
					OFS_STATUS: rd_data = {2'b00, status_q};
					OFS_SELECT: rd_data = dip_q;
					default:    rd_data = 8'hff;
				endcase
			end
		end

		// result bytes go in after the command byte of this access
		for (int i = 0; i < 5; i++) begin
			idx = {1'b0, push_base} + (PW + 1)'(i);
			if (idx >= (PW + 1)'(STORE_DEPTH)) idx = idx - (PW + 1)'(STORE_DEPTH);
			if (3'(i) < push_cnt) store_d[idx[PW-1:0]] = push_data[i];
		end
	end

	assign irq_next = irq_d;
	assign irq_num  = dip_q[6] ? IRQ_ALTERNATE : IRQ_PRIMARY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) store_q[i] <= '0;
			pending_q <= '0;
			pos_q     <= '0;
			status_q  <= '0;
			compl_q   <= '0;
			error_q   <= '0;
			drive_q   <= 1'b0;
			control_q <= '0;
			irq_q     <= 1'b0;
			present_q <= 2'b11;
			dip_q     <= 8'hff;
			for (int i = 0; i < DRIVE_SLOTS; i++) begin
				cyl_q[i]      <= '0;
				head_q[i]     <= '0;
				sector_q[i]   <= '0;
				count_q[i]    <= '0;
				stepopt_q[i]  <= '0;
				cyl_lim_q[i]  <= CYL_LIMIT_RST;
				head_lim_q[i] <= HEAD_LIMIT_RST;
				rcs_q[i]      <= RCS_RST;
				precomp_q[i]  <= PRECOMP_RST;
				ecc_q[i]      <= ECC_LEN_RST;
			end
		end else begin
			store_q    <= store_d;
			pending_q  <= pending_d;
			pos_q      <= pos_d;
			status_q   <= status_d;
			compl_q    <= compl_d;
			error_q    <= error_d;
			drive_q    <= drive_d;
			control_q  <= control_d;
			irq_q      <= irq_d;
			cyl_q      <= cyl_d;
			head_q     <= head_d;
			sector_q   <= sector_d;
			count_q    <= count_d;
			stepopt_q  <= stepopt_d;
			cyl_lim_q  <= cyl_lim_d;
			head_lim_q <= head_lim_d;
			rcs_q      <= rcs_d;
			precomp_q  <= precomp_d;
			ecc_q      <= ecc_d;
			if (cfg_we) begin
				case (cfg_addr)
					REG_DRIVE_PRESENT: present_q <= cfg_wdata[1:0];
					REG_DIP_SWITCHES:  dip_q     <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CW'(STORE_DEPTH))
		else $error("byte count beyond store depth");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(STORE_DEPTH - 1))
		else $error("store position out of range");

	a_irq_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(irq_q) |-> $past(step && acc.cmd == BUS_WR && acc.off == OFS_CONTROL
			&& !acc.wdata[1]))
		else $error("irq dropped without a control write");

	a_launch_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && launch_go |=> (status_q & ST_INTERRUPT) != '0 && pending_q != '0
			&& pos_q == '0)
		else $error("launch left no result bytes queued");

endmodule

[hw/rtl/xt_disk_controller_host_interface_top.sv]
// Host register port of a two-drive XT-class disk controller. Each input word is one byte-wide
// bus access (read or write at offsets 0..3) and yields exactly one output word carrying the
// byte read (0xff on writes), the interrupt line level after the access and the interrupt
// number picked by switch bit 6. One access is taken every cycle while the result register
// is not stalled; it waits in the input register, and the register file and the result
// register capture its update and its result word at the same edge. A stalled result
// register holds the input register, which then holds the input side. Command blocks written
// at offset 0 are decoded combinationally when their last byte is processed, and the result
// bytes are queued for reads at offset 0. Configuration writes are only to be issued while no
// access is in flight.
module xt_disk_controller_host_interface_top
	import xdh_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // write_data[7:0]
	input  logic [2:0]  s_axis_tuser,  // command[0], offset[2:1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // read_data[7:0], irq_active[8], irq_number[11:9]
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [7:0]  cfg_wdata
);

	logic       valid_s1;
	access_t    acc_s1;
	logic       adv;
	logic       out_valid_q;
	logic [7:0] rd_q;
	logic       irq_q;
	logic [2:0] irqn_q;
	logic [7:0] rd_data;
	logic       irq_next;
	logic [2:0] irq_num;

	// access in the input register is processed as soon as the result register frees up
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			acc_s1.cmd   <= s_axis_tuser[0];
			acc_s1.off   <= s_axis_tuser[2:1];
			acc_s1.wdata <= s_axis_tdata;
		end
	end

	xdh_regs #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.acc       (acc_s1),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.rd_data   (rd_data),
		.irq_next  (irq_next),
		.irq_num   (irq_num)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_q   <= rd_data;
			irq_q  <= irq_next;
			irqn_q <= irq_num;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, irqn_q, irq_q, rd_q};

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import xdh_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int STALL_LIMIT = 2000;
	localparam int DEPTH       = STORE_DEPTH_DEF;
	localparam int CMD_BYTES   = 6;

	localparam logic [7:0] IDLE_BYTE   = 8'hff;
	localparam logic [7:0] CC_ERROR    = 8'h02;
	localparam logic [7:0] CC_DRIVE1   = 8'h20;
	localparam int         CTRL_IRQ_EN = 1;
	localparam int         DIP_IRQ_SEL = 6;

	typedef struct packed {
		logic [7:0] rdata;
		logic       irq_on;
		logic [2:0] irq_num;
	} port_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_addr = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	xt_disk_controller_host_interface_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	access_t     access_q [$];
	port_reply_t expected_replies [$];

	int unsigned queued = 0, accepted = 0, writes_seen = 0, checked = 0;
	int unsigned errors = 0, launches = 0, bad_ops = 0, settings = 1;
	int unsigned send_gap = 0, recv_gap = 0, stuck_cycles = 0;
	logic        send_steady = 1'b0, recv_steady = 1'b0;

	// controller state as the host sees it; geometry limits other than ECC length
	// never reach a read and are not kept
	logic [1:0] cfg_present;
	logic [7:0] cfg_dip;
	logic [7:0] blk [DEPTH];
	int unsigned n_pend, rd_pos;
	logic [5:0] stat;
	logic [7:0] cc, err, ctrl;
	logic       sel_drive, irq_lvl;
	logic [9:0] cyl  [DRIVE_SLOTS];
	logic [4:0] head [DRIVE_SLOTS];
	logic [5:0] sect [DRIVE_SLOTS];
	logic [7:0] ecc  [DRIVE_SLOTS];

	function automatic void model_reset();
		cfg_present = 2'b11;
		cfg_dip = 8'hff;
		foreach (blk[i]) blk[i] = '0;
		n_pend = 0;
		rd_pos = 0;
		stat = '0;
		cc = '0;
		err = '0;
		ctrl = '0;
		sel_drive = 1'b0;
		irq_lvl = 1'b0;
		foreach (cyl[d]) begin
			cyl[d] = '0;
			head[d] = '0;
			sect[d] = '0;
			ecc[d] = ECC_LEN_RST;
		end
	endfunction

	function automatic logic op_known(input logic [7:0] v);
		case (v)
			OP_TEST_READY, OP_RECAL, OP_SENSE, OP_FMT_DRIVE, OP_VERIFY, OP_FMT_TRACK,
			OP_FMT_BAD, OP_READ, OP_WRITE, OP_SEEK, OP_INIT_DRIVE, OP_ECC_LEN, OP_RD_BUF,
			OP_WR_BUF, OP_RAM_DIAG, OP_DRV_DIAG, OP_CTL_DIAG, OP_RD_LONG,
			OP_WR_LONG: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void queue_byte(input logic [7:0] v);
		if (n_pend >= DEPTH)
			return;
		blk[(rd_pos + n_pend) % DEPTH] = v;
		n_pend++;
	endfunction

	function automatic void queue_chs();
		queue_byte({2'b00, sel_drive, head[sel_drive]});
		queue_byte({cyl[sel_drive][9:8], sect[sel_drive]});
		queue_byte(cyl[sel_drive][7:0]);
	endfunction

	function automatic void complete(input logic with_err);
		if (ctrl[CTRL_IRQ_EN])
			irq_lvl = 1'b1;
		queue_byte(cc);
		if (with_err && (cc & CC_ERROR) != 0) begin
			queue_byte(err);
			if ((err & ERR_CHS_VALID) != 0)
				queue_chs();
		end
		stat |= ST_FINISH;
	endfunction

	function automatic void latch_chs();
		head[sel_drive] = blk[1][4:0];
		sect[sel_drive] = blk[2][5:0];
		cyl[sel_drive] = {blk[2][7:6], blk[3]};
		err = ERR_CHS_VALID;
	endfunction

	function automatic void drive_check();
		if (int'(sel_drive) >= NUM_DRIVES || !cfg_present[sel_drive]) begin
			cc |= CC_ERROR;
			err |= ERR_NOT_READY;
		end
	endfunction

	function automatic void run_block();
		logic [7:0] prev_err;
		logic       with_err;
		prev_err = err;
		with_err = 1'b1;
		rd_pos = 0;
		n_pend = 0;
		err = '0;
		sel_drive = blk[1][5];
		cc = sel_drive ? CC_DRIVE1 : '0;
		launches++;
		case (blk[0])
			OP_TEST_READY: begin
				with_err = 1'b0;
				drive_check();
			end
			OP_SENSE: begin
				queue_byte(prev_err & ERR_SENSE_MASK);
				queue_chs();
				with_err = 1'b0;
			end
			OP_RECAL: latch_chs();
			OP_FMT_DRIVE, OP_VERIFY, OP_FMT_TRACK, OP_FMT_BAD, OP_SEEK, OP_DRV_DIAG,
			OP_WRITE, OP_WR_LONG: begin
				latch_chs();
				drive_check();
			end
			OP_READ, OP_RD_LONG: begin
				latch_chs();
				drive_check();
				with_err = 1'b0;
			end
			OP_INIT_DRIVE: begin
				latch_chs();
				ecc[sel_drive] = blk[13];
			end
			OP_ECC_LEN: queue_byte(ecc[sel_drive]);
			default: ;
		endcase
		complete(with_err);
	endfunction

	function automatic void data_write(input logic [7:0] v);
		if (n_pend == 0) begin
			rd_pos = 0;
			n_pend = CMD_BYTES;
			stat &= ~(ST_READY | ST_INPUT);
			if (v == OP_INIT_DRIVE) begin
				n_pend = BLOCK_BYTES;
			end else if (!op_known(v)) begin
				// bad opcode: answered at once, the opcode itself is not stored
				n_pend = 0;
				stat |= ST_INPUT;
				cc = CC_BAD_CMD;
				bad_ops++;
				complete(1'b1);
				return;
			end
			stat |= ST_REQUEST;
		end
		blk[rd_pos] = v;
		rd_pos = (rd_pos + 1) % DEPTH;
		stat |= ST_READY;
		n_pend--;
		if (n_pend == 0) begin
			stat &= ~(ST_COMMAND | ST_REQUEST | ST_READY);
			stat |= ST_INPUT;
			run_block();
		end
	endfunction

	function automatic logic [7:0] data_read();
		logic [7:0] v;
		if (n_pend == 0)
			return IDLE_BYTE;
		v = blk[rd_pos];
		rd_pos = (rd_pos + 1) % DEPTH;
		stat &= ~ST_INTERRUPT;
		n_pend--;
		if (n_pend == 0) begin
			stat &= ~(ST_INPUT | ST_REQUEST | ST_SELECT);
			stat |= ST_COMMAND;
		end
		return v;
	endfunction

	function automatic port_reply_t host_access(input access_t a);
		port_reply_t r;
		r.rdata = IDLE_BYTE;
		if (a.cmd == BUS_WR) begin
			case (a.off)
				OFS_DATA: data_write(a.wdata);
				OFS_STATUS: begin
					foreach (cyl[d]) begin
						cyl[d] = '0;
						head[d] = '0;
						sect[d] = '0;
					end
					cc = '0;
					stat = ST_COMMAND | ST_READY;
					foreach (blk[i]) blk[i] = '0;
					rd_pos = 0;
					n_pend = 0;
				end
				OFS_SELECT: begin
					stat &= ~ST_INTERRUPT;
					stat |= ST_SELECT;
				end
				default: begin
					ctrl = a.wdata;
					if (!a.wdata[CTRL_IRQ_EN])
						irq_lvl = 1'b0;
				end
			endcase
		end else begin
			case (a.off)
				OFS_DATA:   r.rdata = data_read();
				OFS_STATUS: r.rdata = {2'b00, stat};
				OFS_SELECT: r.rdata = cfg_dip;
				default: ;
			endcase
		end
		r.irq_on = irq_lvl;
		r.irq_num = cfg_dip[DIP_IRQ_SEL] ? IRQ_ALTERNATE : IRQ_PRIMARY;
		return r;
	endfunction

	function automatic int unsigned pick_gap(input logic steady);
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// host side: one bus access per word
	always @(posedge clk or negedge arst_n) begin : drive_bus
		access_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			send_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap != 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (access_q.size() != 0) begin
				nxt = access_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= nxt.wdata;
				s_axis_tuser <= {nxt.off, nxt.cmd};
				send_gap <= pick_gap(send_steady);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// prediction on acceptance, checking on each reply word, reply-side pacing
	always @(posedge clk or negedge arst_n) begin : watch_bus
		access_t     acc;
		port_reply_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_DRIVE_PRESENT)
					cfg_present = cfg_wdata[1:0];
				else
					cfg_dip = cfg_wdata;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				acc.cmd = s_axis_tuser[0];
				acc.off = s_axis_tuser[2:1];
				acc.wdata = s_axis_tdata;
				if (acc.cmd == BUS_WR)
					writes_seen++;
				accepted++;
				expected_replies.push_back(host_access(acc));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: reply word %h with none expected", $time, m_axis_tdata);
					errors++;
				end else begin
					want = expected_replies.pop_front();
					if (m_axis_tdata[7:0] !== want.rdata) begin
						$display("%0t: read_data expected %h got %h", $time, want.rdata,
							m_axis_tdata[7:0]);
						errors++;
					end
					if (m_axis_tdata[8] !== want.irq_on) begin
						$display("%0t: irq_active expected %b got %b", $time, want.irq_on,
							m_axis_tdata[8]);
						errors++;
					end
					if (m_axis_tdata[11:9] !== want.irq_num) begin
						$display("%0t: irq_number expected %0d got %0d", $time, want.irq_num,
							m_axis_tdata[11:9]);
						errors++;
					end
					checked++;
				end
			end
			if (recv_gap != 0) begin
				m_axis_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				m_axis_tready <= 1'b1;
				recv_gap <= pick_gap(recv_steady);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	function automatic void put(input logic cmd, input logic [1:0] off, input logic [7:0] v);
		access_t a;
		a.cmd = cmd;
		a.off = off;
		a.wdata = v;
		access_q.push_back(a);
		queued++;
	endfunction

	function automatic logic [7:0] pick_known();
		logic [7:0] op;
		if ($urandom_range(0, 9) == 0)
			return OP_INIT_DRIVE;
		do op = 8'($urandom_range(0, 255)); while (!op_known(op));
		return op;
	endfunction

	function automatic void put_reads(input int unsigned n);
		repeat (n) put(BUS_RD, OFS_DATA, 8'($urandom_range(0, 255)));
	endfunction

	function automatic void random_burst();
		int unsigned r, len;
		logic [7:0]  op;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			// complete block, then mostly drain its result bytes
			op = pick_known();
			len = (op == OP_INIT_DRIVE) ? BLOCK_BYTES : CMD_BYTES;
			put(BUS_WR, OFS_DATA, op);
			repeat (len - 1) put(BUS_WR, OFS_DATA, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1))
				put(BUS_RD, OFS_STATUS, 8'($urandom_range(0, 255)));
			put_reads($urandom_range(0, 3) != 0 ? $urandom_range(5, 7) : $urandom_range(0, 4));
		end else if (r < 65) begin
			do op = 8'($urandom_range(0, 255)); while (op_known(op));
			put(BUS_WR, OFS_DATA, op);
			put_reads($urandom_range(0, 6));
		end else if (r < 77) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					op = 8'($urandom_range(0, 255));
					op[CTRL_IRQ_EN] = ($urandom_range(0, 3) != 0);
					put(BUS_WR, OFS_CONTROL, op);
				end
				2: put(BUS_WR, OFS_SELECT, 8'($urandom_range(0, 255)));
				default: put(BUS_WR, OFS_STATUS, 8'($urandom_range(0, 255)));
			endcase
		end else if (r < 87) begin
			// block cut short by reads or a controller reset
			op = pick_known();
			len = (op == OP_INIT_DRIVE) ? BLOCK_BYTES : CMD_BYTES;
			put(BUS_WR, OFS_DATA, op);
			repeat ($urandom_range(0, len - 2))
				put(BUS_WR, OFS_DATA, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1))
				put(BUS_WR, OFS_STATUS, 8'($urandom_range(0, 255)));
			else
				put_reads($urandom_range(1, 4));
		end else begin
			repeat ($urandom_range(1, 4))
				put(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
					8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		while (access_q.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_config(input logic [1:0] present, input logic [7:0] dip);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= REG_DRIVE_PRESENT;
		cfg_wdata <= {6'($urandom_range(0, 63)), present};
		@(posedge clk);
		cfg_addr <= REG_DIP_SWITCHES;
		cfg_wdata <= dip;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin : stimulus
		int          phase;
		int unsigned target;
		model_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		put(BUS_RD, OFS_STATUS, 8'h00);
		put(BUS_RD, OFS_SELECT, 8'hff);
		put(BUS_RD, OFS_CONTROL, 8'h00);
		put(BUS_RD, OFS_DATA, 8'hff);        // nothing queued
		put(BUS_WR, OFS_CONTROL, 8'h02);     // interrupt enable
		put(BUS_WR, OFS_SELECT, 8'h00);
		put(BUS_WR, OFS_DATA, 8'hff);        // bad opcode
		put_reads(3);
		put(BUS_WR, OFS_DATA, OP_TEST_READY);
		put(BUS_WR, OFS_DATA, 8'h20);
		put(BUS_RD, OFS_DATA, 8'h00);        // read while block still gathering
		put(BUS_WR, OFS_STATUS, 8'h00);
		put(BUS_WR, OFS_DATA, OP_ECC_LEN);
		put(BUS_WR, OFS_DATA, 8'h20);
		repeat (4) put(BUS_WR, OFS_DATA, 8'h00);
		put(BUS_RD, OFS_STATUS, 8'h00);
		put_reads(2);
		put(BUS_WR, OFS_CONTROL, 8'h00);

		for (phase = 0; phase < 7; phase++) begin
			if (phase > 0) begin
				wait_drained();
				repeat (4) @(posedge clk);
				case (phase)
					1: set_config(2'd0, 8'h00);
					2: set_config(2'd3, 8'hbf);
					3: set_config(2'd1, 8'h40);
					4: set_config(2'd2, 8'hff);
					default: set_config(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				endcase
				@(negedge clk);
			end
			send_steady = (phase == 2 || phase == 5);
			recv_steady = (phase == 3 || phase == 5);
			target = queued + (phase == 0 ? 40 : 60);
			while (queued < target)
				random_burst();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("%0d accesses (%0d writes) checked against %0d replies, %0d switch settings",
			accepted, writes_seen, checked, settings);
		$display("%0d command blocks launched, %0d bad opcodes, %0d mismatches",
			launches, bad_ops, errors);
		if (errors == 0 && expected_replies.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
hw/rtl/xdh_pkg.sv
hw/rtl/xdh_launch.sv
hw/rtl/xdh_regs.sv
hw/rtl/xt_disk_controller_host_interface_top.sv
sim/testbench.sv
